FILE: sv/pol_pkg.sv
// Package with the command codes, status codes and beat layout of the positional ordered list.
`default_nettype none
package pol_pkg;

  localparam int OPCODE_W   = 4;
  localparam int POSITION_W = 8;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [OPCODE_W-1:0] OP_ADD_FRONT    = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_BACK     = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT_AT    = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_FRONT = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_BACK  = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_AT    = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_COUNT        = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_DUMP         = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_CLEAR        = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  element;
    logic                last;
  } out_beat_t;

endpackage
`default_nettype wire

FILE: sv/positional_ordered_list_top.sv
// Top level of the positional ordered list: command decode, shift sequencer and output register.
// An insert at index i moves count-i entries and a remove count-i-1, one entry per cycle.
// A shift runs S_SHIFT, S_DRAIN, then S_INSW for an insert, then S_RESP, which loads the beat.
// Other commands go to S_RESP, an insert at the list end via S_INSW. A dump streams one beat
// per cycle while out_tready allows; the next command is taken the cycle after the last beat loads.
// Reset clears the element count and the control state; list contents stay undefined until written.
`default_nettype none
module positional_ordered_list_top #(
  parameter int LIST_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // opcode[3:0], position[11:4], value[43:12], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // status[1:0], count[8:2], element[40:9], zero pad
  output logic             out_tlast
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_INSW  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_DUMP  = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [AW-1:0]                  src_r, src_nxt;
  logic [AW-1:0]                  end_r, end_nxt;
  logic                           dir_r, dir_nxt;
  logic                           ins_r, ins_nxt;
  logic [AW-1:0]                  idx_r, idx_nxt;
  logic [pol_pkg::VALUE_W-1:0]    val_r, val_nxt;
  logic [pol_pkg::STATUS_W-1:0]   st_r, st_nxt;
  logic [AW-1:0]                  dptr_r, dptr_nxt;
  logic                           pend_r;
  logic [AW-1:0]                  pend_dst_r;

  logic                           out_valid_r, out_valid_nxt;
  pol_pkg::out_beat_t             out_r, out_nxt;

  logic [pol_pkg::OPCODE_W-1:0]   in_op;
  logic [pol_pkg::POSITION_W-1:0] in_pos;
  logic [pol_pkg::VALUE_W-1:0]    in_val;
  logic                           in_fire;
  logic                           slot_free;
  logic                           load;
  logic [CW-1:0]                  cnt_m1;
  logic                           is_empty;
  logic                           is_full;
  logic                           pos_bad;
  logic                           do_ins;
  logic                           do_rem;
  logic [AW-1:0]                  ins_idx;
  logic [AW-1:0]                  rem_idx;
  logic                           dump_last;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [pol_pkg::VALUE_W-1:0]    ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  logic [pol_pkg::VALUE_W-1:0]    ram_rdata;

  assign in_op  = in_tdata[3:0];
  assign in_pos = in_tdata[11:4];
  assign in_val = in_tdata[43:12];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign load      = slot_free && ((state_r == S_RESP) || (state_r == S_DUMP));

  assign cnt_m1    = cnt_r - CW'(1);
  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r >= CW'(LIST_DEPTH));
  assign pos_bad   = (9'(in_pos) >= 9'(cnt_r));
  assign dump_last = (CW'(dptr_r) == cnt_m1);

  assign ram_we    = pend_r || (state_r == S_INSW);
  assign ram_waddr = pend_r ? pend_dst_r : idx_r;
  assign ram_wdata = pend_r ? ram_rdata : val_r;

  always_comb begin
    case (state_r)
      S_SHIFT: ram_raddr = src_r;
      S_DUMP:  ram_raddr = load ? dptr_r + AW'(1) : dptr_r;
      default: ram_raddr = '0;
    endcase
  end

  pol_ram #(
    .WIDTH (pol_pkg::VALUE_W),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    src_nxt   = src_r;
    end_nxt   = end_r;
    dir_nxt   = dir_r;
    ins_nxt   = ins_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    dptr_nxt  = dptr_r;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    ins_idx   = '0;
    rem_idx   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt   = in_val;
          st_nxt    = pol_pkg::ST_OK;
          dptr_nxt  = '0;
          state_nxt = S_RESP;
          case (in_op)
            pol_pkg::OP_ADD_FRONT, pol_pkg::OP_ADD_BACK: begin
              if (is_full) begin
                st_nxt = pol_pkg::ST_FULL;
              end else begin
                do_ins  = 1'b1;
                ins_idx = (in_op == pol_pkg::OP_ADD_FRONT) ? '0 : AW'(cnt_r);
              end
            end
            pol_pkg::OP_INSERT_AT: begin
              if (is_empty) begin
                st_nxt = pol_pkg::ST_EMPTY;
              end else if (pos_bad) begin
                st_nxt = pol_pkg::ST_BADPOS;
              end else if (is_full) begin
                st_nxt = pol_pkg::ST_FULL;
              end else begin
                do_ins  = 1'b1;
                ins_idx = AW'(in_pos);
              end
            end
            pol_pkg::OP_REMOVE_FRONT, pol_pkg::OP_REMOVE_BACK: begin
              if (is_empty) begin
                st_nxt = pol_pkg::ST_EMPTY;
              end else begin
                do_rem  = 1'b1;
                rem_idx = (in_op == pol_pkg::OP_REMOVE_FRONT) ? '0 : AW'(cnt_m1);
              end
            end
            pol_pkg::OP_REMOVE_AT: begin
              if (is_empty) begin
                st_nxt = pol_pkg::ST_EMPTY;
              end else if (pos_bad) begin
                st_nxt = pol_pkg::ST_BADPOS;
              end else begin
                do_rem  = 1'b1;
                rem_idx = AW'(in_pos);
              end
            end
            pol_pkg::OP_DUMP: begin
              if (is_empty) begin
                st_nxt = pol_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            pol_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase

          if (do_ins) begin
            cnt_nxt = cnt_r + CW'(1);
            ins_nxt = 1'b1;
            idx_nxt = ins_idx;
            if (CW'(ins_idx) == cnt_r) begin
              state_nxt = S_INSW;
            end else begin
              src_nxt   = AW'(cnt_m1);
              end_nxt   = ins_idx;
              dir_nxt   = 1'b0;
              state_nxt = S_SHIFT;
            end
          end

          if (do_rem) begin
            cnt_nxt = cnt_m1;
            ins_nxt = 1'b0;
            if (CW'(rem_idx) != cnt_m1) begin
              src_nxt   = rem_idx + AW'(1);
              end_nxt   = AW'(cnt_m1);
              dir_nxt   = 1'b1;
              state_nxt = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        src_nxt = dir_r ? src_r + AW'(1) : src_r - AW'(1);
        if (src_r == end_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = ins_r ? S_INSW : S_RESP;
      end
      S_INSW: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            dptr_nxt = dptr_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt         = out_r;
    out_valid_nxt   = out_tready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt   = 1'b1;
      out_nxt.count   = pol_pkg::COUNT_W'(cnt_r);
      if (state_r == S_DUMP) begin
        out_nxt.status  = pol_pkg::ST_OK;
        out_nxt.element = ram_rdata;
        out_nxt.last    = dump_last;
      end else begin
        out_nxt.status  = st_r;
        out_nxt.element = '0;
        out_nxt.last    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= (state_r == S_SHIFT);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    end_r      <= end_nxt;
    dir_r      <= dir_nxt;
    ins_r      <= ins_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    st_r       <= st_nxt;
    dptr_r     <= dptr_nxt;
    pend_dst_r <= dir_r ? src_r - AW'(1) : src_r + AW'(1);
    out_r      <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {7'd0, out_r.element, out_r.count, out_r.status};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LIST_DEPTH))
    else $error("element count above list depth");

  a_idle_no_write : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("list store written while idle");

  a_error_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != pol_pkg::ST_OK) |-> out_r.last)
    else $error("error status on a beat that is not last");

  a_dump_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (CW'(dptr_r) < cnt_r))
    else $error("dump pointer beyond element count");

  a_dump_entry : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == pol_pkg::OP_DUMP && !is_empty) |=> (state_r == S_DUMP))
    else $error("dump of a filled list did not start");

endmodule
`default_nettype wire

FILE: sv/pol_ram.sv
// Generic single write port RAM with one registered read port.
`default_nettype none
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
